// ===== hw/rtl/ard_pkg.sv =====
`timescale 1ns / 1ps

package ard_pkg;

   // Table geometry
   localparam int REGION_ENTRIES    = 16;
   localparam int DEVICE_BITS       = 8;
   localparam int DEVICE_FIELD_BITS = 8;
   localparam int DEV_KEEP_BITS     = (DEVICE_BITS < DEVICE_FIELD_BITS) ?
                                      DEVICE_BITS : DEVICE_FIELD_BITS;
   localparam int COUNT_BITS        = $clog2(REGION_ENTRIES + 1);

   // Request kinds
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_MAP    = 2'd1;
   localparam logic [1:0] KIND_UNMAP  = 2'd2;

   // Per-cycle command broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_LOOK  = 2'd1,
      OP_MAP   = 2'd2,
      OP_UNMAP = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [1:0]                       kind;
      logic [31:0]                      address;
      logic [31:0]                      region_length;
      logic [DEVICE_FIELD_BITS-1:0]     device_number;
      logic [31:0]                      target_offset;
   } req_type;

   typedef struct packed {
      logic                             hit;
      logic [DEVICE_FIELD_BITS-1:0]     hit_device;
      logic [31:0]                      hit_base;
      logic [31:0]                      translated_offset;
      logic                             table_full;
   } rsp_type;

   // One region as held in a cell
   typedef struct packed {
      logic [31:0]                      base;
      logic [31:0]                      length;
      logic [DEV_KEEP_BITS-1:0]         device;
      logic [31:0]                      offset;
   } entry_type;

   // Link from a cell to its right neighbor (higher index)
   typedef struct packed {
      entry_type                        ent;
      logic                             valid;
      logic                             open;   // slot is past the insert point
      logic                             kill;   // a match sits at or left of here
      logic                             found;  // a lookup hit sits at or left of here
   } link_type;

   // Link from a cell to its left neighbor (lower index)
   typedef struct packed {
      entry_type                        ent;
      logic                             valid;
   } back_type;

endpackage

// ===== hw/rtl/ard_cell.sv =====
`timescale 1ns / 1ps

module ard_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ard_pkg::cell_op_type  op,
   input  ard_pkg::entry_type    key,
   input  ard_pkg::link_type     left_in,
   output ard_pkg::link_type     right_out,
   input  ard_pkg::back_type     right_in,
   output ard_pkg::back_type     left_out,
   output ard_pkg::entry_type    ent,
   output logic                  valid,
   output logic                  pick
);
   import ard_pkg::*;

   entry_type   ent_ff, ent_in;
   logic        valid_ff, valid_in;
   logic        hit_ff, hit_in;
   logic        open_w, match_w, kill_w, contains_w;
   logic [32:0] end_w;

   // Local compares against the broadcast key
   assign open_w     = !valid_ff || (ent_ff.base > key.base);
   assign match_w    = valid_ff && (ent_ff.base == key.base) &&
                       (ent_ff.length == key.length);
   assign kill_w     = left_in.kill || match_w;
   assign end_w      = {1'b0, ent_ff.base} + {1'b0, ent_ff.length};
   assign contains_w = valid_ff && (key.base >= ent_ff.base) &&
                       ({1'b0, key.base} < end_w);

   // Next contents: hold, record the lookup hit, insert, shift right on map, shift left on unmap
   always_comb begin
      ent_in   = ent_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      case (op)
         OP_LOOK: begin
            hit_in = contains_w;
         end
         OP_MAP: begin
            if (open_w) begin
               if (left_in.open) begin
                  ent_in   = left_in.ent;
                  valid_in = left_in.valid;
               end else begin
                  ent_in   = key;
                  valid_in = 1'b1;
               end
            end
         end
         OP_UNMAP: begin
            if (kill_w) begin
               ent_in   = right_in.ent;
               valid_in = right_in.valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      ent_ff <= ent_in;
   end

   // Neighbor links
   always_comb begin
      right_out.ent   = ent_ff;
      right_out.valid = valid_ff;
      right_out.open  = open_w;
      right_out.kill  = kill_w;
      right_out.found = left_in.found || hit_ff;
      left_out.ent    = ent_ff;
      left_out.valid  = valid_ff;
   end

   assign ent   = ent_ff;
   assign valid = valid_ff;
   assign pick  = hit_ff && !left_in.found;

endmodule

// ===== hw/rtl/address_region_decoder_unit.sv =====
`timescale 1ns / 1ps

// Address region decoder: a sorted table of up to REGION_ENTRIES regions held
// in a row of cells, one region per cell, kept in ascending base order.
// Request channel (req_valid/req_ready/req_data): kind selects lookup, map or
// unmap. Response channel (rsp_valid/rsp_ready/rsp_data): exactly one beat per
// request, in request order.
// Path of each request from its acceptance to rsp_valid: a lookup passes
//   S_EXEC (cells compare in parallel) and S_LOOK (first-hit select and
//   offset add); a map and other kinds respond from S_EXEC; an unmap passes
//   S_EXEC, then S_UNMAP removes the matching regions, one removal per cycle
//   as the row shifts down, then responds. One request is in flight at a
//   time; the next one is taken the cycle after the response is registered.
// The response sits in an output register: a new request is accepted while an
// earlier response still waits. If rsp_ready stays low, the next request waits
// in its final step until the register frees up; a map waits there with the
// table untouched, an unmap after its removals are done.
// Reset (synchronous) empties the table and drops any pending response.
module address_region_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ard_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ard_pkg::rsp_type  rsp_data
);
   import ard_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EXEC  = 2'd1,
      S_LOOK  = 2'd2,
      S_UNMAP = 2'd3
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   cell_op_type           op;
   entry_type             key;
   entry_type             sel;
   entry_type             ents  [REGION_ENTRIES];
   link_type              links [REGION_ENTRIES+1];
   back_type              backs [REGION_ENTRIES+1];
   logic [REGION_ENTRIES-1:0] valid_vec;
   logic [REGION_ENTRIES-1:0] pick_vec;
   logic                  slot_free;
   logic                  full;
   logic                  any_match;

   // Key broadcast to the cells
   always_comb begin
      key.base   = req_ff.address;
      key.length = req_ff.region_length;
      key.device = req_ff.device_number[DEV_KEEP_BITS-1:0];
      key.offset = req_ff.target_offset;
   end

   // Chain ends
   assign links[0]              = '0;
   assign backs[REGION_ENTRIES] = '0;

   // Row of cells
   for (genvar i = 0; i < REGION_ENTRIES; i++) begin : g_cell
      ard_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .key       (key),
         .left_in   (links[i]),
         .right_out (links[i+1]),
         .right_in  (backs[i+1]),
         .left_out  (backs[i]),
         .ent       (ents[i]),
         .valid     (valid_vec[i]),
         .pick      (pick_vec[i])
      );
   end

   assign any_match = links[REGION_ENTRIES].kill;
   assign full      = (count_ff == COUNT_BITS'(REGION_ENTRIES));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // First-hit select, one-hot OR
   always_comb begin
      sel = '0;
      for (int i = 0; i < REGION_ENTRIES; i++) begin
         if (pick_vec[i]) begin
            sel = sel | ents[i];
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      count_in     = count_ff;
      op           = OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (req_ff.kind)
               KIND_LOOKUP: begin
                  op       = OP_LOOK;
                  state_in = S_LOOK;
               end
               KIND_MAP: begin
                  if (slot_free) begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.table_full = 1'b1;
                     end else begin
                        op       = OP_MAP;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               KIND_UNMAP: begin
                  state_in = S_UNMAP;
               end
               default: begin
                  if (slot_free) begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_UNMAP: begin
            // remove the first remaining match each cycle
            if (any_match) begin
               op       = OP_UNMAP;
               count_in = count_ff - 1'b1;
            end else if (slot_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOOK: begin
            if (slot_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               if (|pick_vec) begin
                  rsp_in.hit               = 1'b1;
                  rsp_in.hit_device        = DEVICE_FIELD_BITS'(sel.device);
                  rsp_in.hit_base          = sel.base;
                  rsp_in.translated_offset = sel.offset + (req_ff.address - sel.base);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // occupied cells match the fill count
   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(REGION_ENTRIES))
      else $error("entry count beyond table size");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick_vec))
      else $error("more than one cell selected on lookup");

   a_map_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && req_ff.kind == KIND_MAP && slot_free && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("map did not add one entry");

   a_unmap_shrink: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UNMAP && any_match)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("unmap pass did not remove one entry");
`endif

endmodule

// ===== tb/ard_region_checker.sv =====
`timescale 1ns / 1ps

module ard_region_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ard_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ard_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_beats
);
   import ard_pkg::*;

   // Shadow region table, ascending base, ties in insertion order
   logic [31:0]              region_base   [REGION_ENTRIES];
   logic [31:0]              region_length [REGION_ENTRIES];
   logic [DEV_KEEP_BITS-1:0] region_device [REGION_ENTRIES];
   logic [31:0]              region_offset [REGION_ENTRIES];
   int                       region_count;

   rsp_type                  expected_rsp_q [$];
   rsp_type                  expected_beat;
   rsp_type                  predicted_beat;

   function automatic void move_region(input int dst, input int src);
      region_base[dst]   = region_base[src];
      region_length[dst] = region_length[src];
      region_device[dst] = region_device[src];
      region_offset[dst] = region_offset[src];
   endfunction

   // Apply one request beat to the shadow table and return its response
   function automatic rsp_type decode_beat(input req_type beat);
      rsp_type     result;
      logic [32:0] region_end;
      int          i;
      int          slot;
      int          kept;
      result = '0;
      case (beat.kind)
         KIND_LOOKUP: begin
            for (i = 0; i < region_count; i++) begin
               // end at 33 bits so regions at the top never wrap
               region_end = {1'b0, region_base[i]} + {1'b0, region_length[i]};
               if (!result.hit && beat.address >= region_base[i] &&
                   {1'b0, beat.address} < region_end) begin
                  result.hit = 1'b1;
                  result.hit_device[DEV_KEEP_BITS-1:0] = region_device[i];
                  result.hit_base = region_base[i];
                  result.translated_offset =
                     region_offset[i] + (beat.address - region_base[i]);
               end
            end
         end
         KIND_MAP: begin
            if (region_count >= REGION_ENTRIES) begin
               result.table_full = 1'b1;
            end else begin
               slot = 0;
               while (slot < region_count && region_base[slot] <= beat.address)
                  slot++;
               for (i = region_count; i > slot; i--)
                  move_region(i, i - 1);
               region_base[slot]   = beat.address;
               region_length[slot] = beat.region_length;
               region_device[slot] = beat.device_number[DEV_KEEP_BITS-1:0];
               region_offset[slot] = beat.target_offset;
               region_count++;
            end
         end
         KIND_UNMAP: begin
            // compact the table, dropping every exact base/length match
            kept = 0;
            for (i = 0; i < region_count; i++) begin
               if (!(region_base[i] == beat.address &&
                     region_length[i] == beat.region_length)) begin
                  if (kept != i)
                     move_region(kept, i);
                  kept++;
               end
            end
            region_count = kept;
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      end
   endtask

   // Responses are compared before the same edge's request is predicted
   always @(posedge clock) begin
      if (reset) begin
         region_count = 0;
         expected_rsp_q.delete();
         fail_count = 0;
         pending_beats <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected rsp beat, expected none, actual 0x%0h",
                        $time, rsp_data);
            end else begin
               expected_beat = expected_rsp_q.pop_front();
               check_field("hit", 32'(expected_beat.hit), 32'(rsp_data.hit));
               check_field("hit_device", 32'(expected_beat.hit_device),
                           32'(rsp_data.hit_device));
               check_field("hit_base", expected_beat.hit_base, rsp_data.hit_base);
               check_field("translated_offset", expected_beat.translated_offset,
                           rsp_data.translated_offset);
               check_field("table_full", 32'(expected_beat.table_full),
                           32'(rsp_data.table_full));
            end
         end
         if (req_valid && req_ready) begin
            predicted_beat = decode_beat(req_data);
            expected_rsp_q.insert(expected_rsp_q.size(), predicted_beat);
         end
         pending_beats <= expected_rsp_q.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ard_pkg::*;

   localparam int         RANDOM_BEATS = 1900;
   localparam int         POOL_DEPTH   = 32;
   localparam logic [1:0] KIND_SPARE   = 2'd3;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    steady_flow = 1'b0;
   int      fail_count;
   int      pending_beats;

   // Recently mapped base/length pairs, used to aim lookups and unmaps
   logic [31:0] pool_base   [POOL_DEPTH];
   logic [31:0] pool_length [POOL_DEPTH];
   int          pool_fill = 0;
   int          pool_next = 0;

   address_region_decoder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ard_region_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side stalls about 18% of cycles, except in the steady window
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 18);
   end

   function automatic req_type make_beat(input logic [1:0] kind, input logic [31:0] address,
                                         input logic [31:0] length, input logic [7:0] device,
                                         input logic [31:0] offset);
      req_type beat;
      beat.kind          = kind;
      beat.address       = address;
      beat.region_length = length;
      beat.device_number = device;
      beat.target_offset = offset;
      return beat;
   endfunction

   function automatic logic [31:0] pick_base();
      case ($urandom_range(5))
         0:       return 32'($urandom_range(3)) << 30;   // shared bases, many ties
         1:       return 32'hFFFF_FFFF - $urandom_range(255);
         5:       return $urandom;
         default: return 32'h1000_0000 + $urandom_range(32'hFFFF);
      endcase
   endfunction

   function automatic logic [31:0] pick_length(input logic [31:0] base);
      case ($urandom_range(9))
         0:       return 32'h0;
         5, 6:    return $urandom_range(1, 32'h10_0000);
         7:       return $urandom;
         8:       return 32'hFFFF_FFFF;
         9:       return 32'h0 - base;   // ends exactly at the top of the space
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   // Addresses inside a region and right on its edges
   function automatic logic [31:0] aim_address(input logic [31:0] base,
                                               input logic [31:0] length);
      case ($urandom_range(7))
         4:       return base;
         5:       return base + length - 1;
         6:       return base + length;
         7:       return base - 1;
         default: return (length == 0) ? base : base + ($urandom % length);
      endcase
   endfunction

   function automatic req_type random_beat(input int map_weight);
      req_type beat;
      int      roll;
      int      pick;
      beat = make_beat(KIND_LOOKUP, $urandom, $urandom, 8'($urandom), $urandom);
      roll = $urandom_range(99);
      pick = (pool_fill == 0) ? 0 : $urandom_range(pool_fill - 1);
      if (roll < 2) begin
         beat.kind = KIND_SPARE;
      end else if (roll < 2 + map_weight) begin
         beat.kind          = KIND_MAP;
         beat.address       = pick_base();
         beat.region_length = pick_length(beat.address);
         pool_base[pool_next]   = beat.address;
         pool_length[pool_next] = beat.region_length;
         pool_next = (pool_next + 1) % POOL_DEPTH;
         if (pool_fill < POOL_DEPTH)
            pool_fill++;
      end else if (roll < 42) begin
         beat.kind = KIND_UNMAP;
         if (pool_fill != 0 && $urandom_range(3) != 0) begin
            beat.address       = pool_base[pick];
            beat.region_length = pool_length[pick];
         end else begin
            beat.address       = pick_base();
            beat.region_length = pick_length(beat.address);
         end
      end else if (pool_fill != 0 && $urandom_range(9) < 7) begin
         beat.address = aim_address(pool_base[pick], pool_length[pick]);
      end
      return beat;
   endfunction

   // Hold the beat until accepted; an optional gap comes first
   task automatic send_beat(input req_type beat);
      int gap;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < 18)
         gap = $urandom_range(1, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // Pause the sender until every outstanding response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0)
         @(posedge clock);
   endtask

   initial begin
      int map_weight;
      int drain_cycles;
      map_weight = 20;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table misses
      send_beat(make_beat(KIND_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0));
      // offset near the top so the translation wraps
      send_beat(make_beat(KIND_MAP, 32'h1000, 32'h100, 8'hFF, 32'hFFFF_FFF0));
      send_beat(make_beat(KIND_LOOKUP, 32'h1000, 32'h0, 8'h00, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'h10FF, 32'h0, 8'h00, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'h1100, 32'h0, 8'h00, 32'h0));
      // region ending exactly at 2^32, then one reaching past it
      send_beat(make_beat(KIND_MAP, 32'hFFFF_FF00, 32'h100, 8'h00, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      send_beat(make_beat(KIND_MAP, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h5A, 32'h1234_5678));
      send_beat(make_beat(KIND_LOOKUP, 32'h5, 32'h0, 8'h00, 32'h0));
      // zero length matches nothing
      send_beat(make_beat(KIND_MAP, 32'h2000, 32'h0, 8'h33, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'h2000, 32'h0, 8'h00, 32'h0));
      // equal base goes after the existing region
      send_beat(make_beat(KIND_MAP, 32'h1000, 32'h80, 8'h11, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'h1010, 32'h0, 8'h00, 32'h0));
      send_beat(make_beat(KIND_UNMAP, 32'h1000, 32'h100, 8'h00, 32'h0));
      send_beat(make_beat(KIND_LOOKUP, 32'h1010, 32'h0, 8'h00, 32'h0));
      // unmap with no match, then the unused kind
      send_beat(make_beat(KIND_UNMAP, 32'h1000, 32'h7F, 8'h00, 32'h0));
      send_beat(make_beat(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      // four regions held: fill the table, overflow once, then one unmap clears the copies
      for (int i = 0; i <= REGION_ENTRIES - 4; i++)
         send_beat(make_beat(KIND_MAP, 32'h3000, 32'h10, 8'(i), 32'(i)));
      send_beat(make_beat(KIND_LOOKUP, 32'h300F, 32'h0, 8'h00, 32'h0));
      send_beat(make_beat(KIND_UNMAP, 32'h3000, 32'h10, 8'h00, 32'h0));
      wait_drained();

      // random traffic; the map/unmap balance shifts so the table fills and drains
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 150 == 0)
            map_weight = $urandom_range(10, 35);
         if (n == 700)
            steady_flow <= 1'b1;
         if (n == 1000)
            steady_flow <= 1'b0;
         if (n % 400 == 399)
            wait_drained();
         send_beat(random_beat(map_weight));
      end

      req_valid <= 1'b0;
      drain_cycles = 0;
      @(posedge clock);
      while (pending_beats != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_beats != 0)
            $display("%0t: %0d expected rsp beats never arrived", $time, pending_beats);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
